// File: rtl/lisp_pkg.sv
package lisp_pkg;

  localparam int VALUE_W = 32;
  localparam int LEN_W   = 11;

  typedef struct packed {
    logic [VALUE_W-1:0] key;
    logic               last;
    logic               settled;
    logic               appended;
  } tok_t;

endpackage

// File: rtl/lisp_in_if.sv
interface lisp_in_if import lisp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               seq_end;

  modport source (output valid, output value, output seq_end, input ready);
  modport sink   (input valid, input value, input seq_end, output ready);
endinterface

// File: rtl/lisp_out_if.sv
interface lisp_out_if import lisp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] lis_length;
  logic             is_final;
  logic             overflow;

  modport source (output valid, output lis_length, output is_final, output overflow,
                  input ready);
  modport sink   (input valid, input lis_length, input is_final, input overflow,
                  output ready);
endinterface

// File: rtl/lis_length_patience_tails_top.sv
// channel  | role   | payload
// ---------+--------+---------------------------------------
// in_ch    | sink   | value[31:0] signed, seq_end
// out_ch   | source | lis_length[10:0], is_final, overflow
//
// One transaction enters per cycle while out_ch is not stalled; each result passes
// through every register of the tail-cell chain and then the output register.
// Reset clears every cell's occupancy and the count at once; no clearing pass.
// A stalled result at out_ch freezes the whole chain and drops in_ch.ready.
module lis_length_patience_tails_top import lisp_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic clk,
  input  logic rst_n,
  lisp_in_if.sink    in_ch,
  lisp_out_if.source out_ch
);

  logic adv;
  logic tok_vld [MAX_LEN+1];
  tok_t tok     [MAX_LEN+1];

  assign in_ch.ready     = adv;
  assign tok_vld[0]      = in_ch.valid;
  assign tok[0].key      = in_ch.value;
  assign tok[0].last     = in_ch.seq_end;
  assign tok[0].settled  = 1'b0;
  assign tok[0].appended = 1'b0;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lisp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .tok_vld_i (tok_vld[k]),
      .tok_i     (tok[k]),
      .tok_vld_o (tok_vld[k+1]),
      .tok_o     (tok[k+1])
    );
  end

  lisp_out #(
    .MAX_LEN (MAX_LEN)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_vld_i (tok_vld[MAX_LEN]),
    .tok_i     (tok[MAX_LEN]),
    .adv       (adv),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/lisp_cell.sv
module lisp_cell import lisp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic tok_vld_i,
  input  tok_t tok_i,
  output logic tok_vld_o,
  output tok_t tok_o
);

  logic [VALUE_W-1:0] tail_r, tail_nxt;
  logic               occ_r, occ_nxt;
  logic               tok_vld_r;
  tok_t               tok_r, tok_nxt;

  always_comb begin
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    tok_nxt  = tok_i;
    if (tok_vld_i && !tok_i.settled) begin
      if (!occ_r) begin
        tail_nxt         = tok_i.key;
        occ_nxt          = 1'b1;
        tok_nxt.settled  = 1'b1;
        tok_nxt.appended = 1'b1;
      end else if ($signed(tail_r) >= $signed(tok_i.key)) begin
        tail_nxt        = tok_i.key;
        tok_nxt.settled = 1'b1;
      end
    end
    // drop occupancy once the sequence's last transaction has passed
    if (tok_vld_i && tok_i.last) begin
      occ_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= 1'b0;
      tok_vld_r <= 1'b0;
    end else if (adv) begin
      occ_r     <= occ_nxt;
      tok_vld_r <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tail_r <= tail_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_vld_o = tok_vld_r;
  assign tok_o     = tok_r;

endmodule

// File: rtl/lisp_out.sv
module lisp_out import lisp_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic tok_vld_i,
  input  tok_t tok_i,
  output logic adv,
  lisp_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_vld_r;
  logic [LEN_W-1:0] len_r, len_ext;
  logic             fin_r;
  logic             ovf_out_r;

  assign adv     = !out_vld_r || out_ch.ready;
  assign cnt_nxt = cnt_r + CNT_W'(tok_i.appended);
  assign ovf_nxt = ovf_r | ~tok_i.settled;

  generate
    if (CNT_W >= LEN_W) begin : g_trunc
      assign len_ext = cnt_nxt[LEN_W-1:0];
    end else begin : g_ext
      assign len_ext = {{(LEN_W-CNT_W){1'b0}}, cnt_nxt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= tok_vld_i;
      if (tok_vld_i) begin
        cnt_r <= tok_i.last ? '0 : cnt_nxt;
        ovf_r <= tok_i.last ? 1'b0 : ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_vld_i) begin
      len_r     <= len_ext;
      fin_r     <= tok_i.last;
      ovf_out_r <= ovf_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.lis_length = len_r;
  assign out_ch.is_final   = fin_r;
  assign out_ch.overflow   = ovf_out_r;

endmodule

// File: dv/tb_lis_length_patience_tails_top.sv
module tb_lis_length_patience_tails_top;
  import lisp_pkg::*;

  localparam int MAX_LEN    = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYC  = MAX_LEN + 16;
  localparam int MAX_SHOWN  = 10;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [LEN_W-1:0] lis_length;
    logic             is_final;
    logic             overflow;
  } lis_result_t;

  typedef enum int {STYLE_WIDE, STYLE_NARROW, STYLE_RISING, STYLE_EDGES} value_style_t;

  logic clk;
  logic rst_n;

  lisp_in_if  in_ch ();
  lisp_out_if out_ch ();

  lis_length_patience_tails_top #(.MAX_LEN(MAX_LEN)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [VALUE_W-1:0] tails [MAX_LEN];
  int          tail_cnt;
  bit          ovf_seen;
  lis_result_t awaited_lis [$];

  int src_idle_pct;
  int snk_stall_pct;
  int n_sent;
  int n_seqs;
  int n_checked;
  int n_ovf_results;
  int n_errors;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic lis_result_t patience_insert(input logic signed [VALUE_W-1:0] v,
                                                  input bit last);
    int          lo;
    int          hi;
    int          mid;
    lis_result_t r;
    lo = 0;
    hi = tail_cnt;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tails[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    if (lo < tail_cnt) begin
      tails[lo] = v;
    end else if (tail_cnt < MAX_LEN) begin
      tails[tail_cnt] = v;
      tail_cnt++;
    end else begin
      ovf_seen = 1'b1;
    end
    r.lis_length = LEN_W'(tail_cnt);
    r.is_final   = last;
    r.overflow   = ovf_seen;
    if (last) begin
      tail_cnt = 0;
      ovf_seen = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] next_value(input value_style_t style,
                                                           input logic signed [VALUE_W-1:0] prev);
    case (style)
      STYLE_WIDE: begin
        return $urandom;
      end
      STYLE_NARROW: begin
        return int'($urandom_range(0, 15)) - 8;
      end
      STYLE_RISING: begin
        if ($urandom_range(9) == 0) return prev - int'($urandom_range(1, 50));
        return prev + int'($urandom_range(0, 40));
      end
      default: begin
        case ($urandom_range(5))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return VAL_MIN + 1;
          3: return VAL_MAX - 1;
          4: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  task automatic send_value(input logic signed [VALUE_W-1:0] v, input bit last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.seq_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    awaited_lis = {awaited_lis, patience_insert(v, last)};
    n_sent++;
    if (last) n_seqs++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (awaited_lis.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic test_extremes();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(0, 1'b0);
    send_value(-1, 1'b0);
    send_value(1, 1'b0);
    send_value(1, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(5, 1'b1);
    send_value(VAL_MAX, 1'b1);
    send_value(VAL_MIN, 1'b1);
    send_value(100, 1'b0);
    send_value(50, 1'b0);
    send_value(0, 1'b0);
    send_value(-50, 1'b0);
    send_value(-100, 1'b1);
    send_value(32'sh5555_5555, 1'b0);
    send_value(32'shAAAA_AAAA, 1'b0);
    send_value(32'sh0000_FFFF, 1'b0);
    send_value(32'shFFFF_0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_full_table();
    logic signed [VALUE_W-1:0] base;
    int                        step;
    src_idle_pct  = 10;
    snk_stall_pct = 10;
    base = -32'sd2000000 + int'($urandom_range(0, 999));
    step = $urandom_range(1, 3000);
    for (int i = 0; i < MAX_LEN + 3; i++) send_value(base + i * step, 1'b0);
    // replace inside a full table, then match the top tail, then drop another append
    send_value(base + step / 2, 1'b0);
    send_value(base + (MAX_LEN - 1) * step, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(VAL_MIN, 1'b1);
    send_value(VAL_MAX, 1'b0);
    send_value(0, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int budget);
    int                        target;
    int                        seq_len;
    value_style_t              style;
    logic signed [VALUE_W-1:0] v;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    target = n_sent + budget;
    while (n_sent < target) begin
      seq_len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      if (seq_len > target - n_sent) seq_len = target - n_sent;
      style   = value_style_t'($urandom_range(3));
      v       = $urandom;
      for (int i = 0; i < seq_len; i++) begin
        v = next_value(style, v);
        send_value(v, i == seq_len - 1);
      end
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    lis_result_t exp_r;
    lis_result_t got_r;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_r.lis_length = out_ch.lis_length;
        got_r.is_final   = out_ch.is_final;
        got_r.overflow   = out_ch.overflow;
        if (awaited_lis.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("ERROR: unexpected result len=%0d final=%0b ovf=%0b",
                     got_r.lis_length, got_r.is_final, got_r.overflow);
        end else begin
          exp_r = awaited_lis.pop_front();
          n_checked++;
          if (exp_r.overflow) n_ovf_results++;
          if (got_r.lis_length !== exp_r.lis_length || got_r.is_final !== exp_r.is_final ||
              got_r.overflow !== exp_r.overflow) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
              $display("ERROR: #%0d exp len=%0d fin=%0b ovf=%0b got len=%0d fin=%0b ovf=%0b",
                       n_checked, exp_r.lis_length, exp_r.is_final, exp_r.overflow,
                       got_r.lis_length, got_r.is_final, got_r.overflow);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles without a transaction", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.seq_end <= 1'b0;
    tail_cnt      = 0;
    ovf_seen      = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    n_sent        = 0;
    n_seqs        = 0;
    n_checked     = 0;
    n_ovf_results = 0;
    n_errors      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_full_table();
    test_random_phase(0, 0, 110);
    test_random_phase(56, 0, 110);
    test_random_phase(0, 56, 110);
    test_random_phase(10, 10, 110);

    repeat (DRAIN_CYC) @(posedge clk);
    $display("Run covered %0d sequences, %0d transactions, %0d results (%0d with overflow):",
             n_seqs, n_sent, n_checked, n_ovf_results);
    $display("extreme values, equal tails, a table filled past %0d entries, and four idle/stall mixes.",
             MAX_LEN);
    if (n_errors == 0 && awaited_lis.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, awaited_lis.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
